// ----- design/ogrc_pkg.sv -----
// Shared types and constants for the occupancy grid ray caster.
package ogrc_pkg;
    localparam int MAP_SIDE_DEF = 512;
    localparam int SLOPE_FRAC_DEF = 16;
    localparam int COORD_W = 9;
    localparam int WIDTH_W = 10;
    localparam int VAL_W = 8;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 10'd512;
    localparam logic signed [VAL_W-1:0] THRESH_RST = 8'sd70;
    localparam logic CFG_MAP_WIDTH = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RAY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_STEP, ST_READ, ST_TEST, ST_OUT
    } t_state;
endpackage

// ----- design/occupancy_grid_ray_cast.sv -----
// Top level of the occupancy grid ray caster.
// Channels: s_axis carries items; tuser[0] is the kind (0 cell write, 1 ray).
// tdata from bit 0: cell_x, cell_y, cell_value, start_x, start_y, end_x, end_y.
// m_axis returns one item per ray: tdata from bit 0: hit, stop_x, stop_y.
// Write items are written to the map as they are accepted and give no result.
// A ray first runs the slope division, then tests one cell of the major
// axis at a time (step, memory read, compare), up to 512 cells, since
// the map memory has a single read port.
// One item is worked on at a time; s_axis_tready is low while a ray runs and
// while its result waits on m_axis. A stalled receiver holds the result.
// The map memory has no reset; cells read before being written are undefined.
// Reset sets map_width to 512 and occupied_threshold to 70.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 map_width, 1 occupied_threshold); do so only while idle.
module occupancy_grid_ray_cast #(
    parameter int MAP_SIDE = ogrc_pkg::MAP_SIDE_DEF,
    parameter int SLOPE_FRAC_BITS = ogrc_pkg::SLOPE_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // cell_x,cell_y,cell_value,start_x,start_y,end_x,end_y
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // hit,stop_x,stop_y
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    localparam int CW = ogrc_pkg::COORD_W;
    localparam int AW = 2 * $clog2(MAP_SIDE);
    localparam int NW = CW + SLOPE_FRAC_BITS;
    localparam int PW = NW + CW;
    localparam logic [CW:0] SIDE_C = (MAP_SIDE > 511) ? (CW+1)'(512) : (CW+1)'(MAP_SIDE);

    ogrc_pkg::t_state r_state, n_state;
    logic [9:0] r_width;
    logic signed [7:0] r_thr;
    // ray context
    logic [CW-1:0] r_amaj, r_aend, r_bmin, r_bend, r_n, r_k, r_a, r_b;
    logic r_xmaj, r_minneg, r_last, r_hit;
    logic [NW-1:0] r_q;
    logic [PW-1:0] r_p;
    logic r_oob;
    logic [23:0] r_out;
    logic r_dfire;

    logic [CW-1:0] w_sx, w_sy, w_ex, w_ey, w_cx, w_cy;
    logic signed [7:0] w_cv;
    assign w_cx = s_axis_tdata[8:0];
    assign w_cy = s_axis_tdata[17:9];
    assign w_cv = s_axis_tdata[25:18];
    assign w_sx = s_axis_tdata[34:26];
    assign w_sy = s_axis_tdata[43:35];
    assign w_ex = s_axis_tdata[52:44];
    assign w_ey = s_axis_tdata[61:53];

    logic [CW:0] w_ew;
    assign w_ew = ({1'b0, r_width} < {1'b0, SIDE_C}) ? r_width : SIDE_C;

    logic [CW-1:0] w_dx, w_dy;
    logic w_xm;
    assign w_dx = (w_ex >= w_sx) ? w_ex - w_sx : w_sx - w_ex;
    assign w_dy = (w_ey >= w_sy) ? w_ey - w_sy : w_sy - w_ey;
    assign w_xm = w_dy < w_dx;

    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // address generation: x + y*w, registered by the memory read port
    logic [CW-1:0] w_cx_t, w_cy_t;
    logic w_we;
    logic [2*CW+1:0] w_widx;
    logic [2*CW+1:0] w_ridx;
    assign w_widx = {{(CW+1){1'b0}}, w_cx} + w_cy * w_ew;
    assign w_we = w_acc && (s_axis_tuser == ogrc_pkg::REQ_WRITE)
        && ({1'b0, w_cx} < w_ew) && ({1'b0, w_cy} < SIDE_C);
    assign w_cx_t = r_xmaj ? r_a : r_b;
    assign w_cy_t = r_xmaj ? r_b : r_a;
    assign w_ridx = {{(CW+1){1'b0}}, w_cx_t} + w_cy_t * w_ew;

    logic signed [7:0] w_rd;
    ogrc_map #(.ADDR_W(AW)) u_map (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(AW'(w_widx)), .i_wdata(w_cv),
        .i_raddr(AW'(w_ridx)), .o_rdata(w_rd)
    );

    logic w_dstart, w_ddone;
    logic [NW-1:0] w_quot, w_num;
    logic [CW-1:0] w_dmag;
    assign w_dmag = r_minneg ? r_bmin - r_bend : r_bend - r_bmin;
    assign w_num = {w_dmag, {SLOPE_FRAC_BITS{1'b0}}};
    ogrc_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_num),
        .i_den(r_n), .o_done(w_ddone), .o_quot(w_quot)
    );

    // next state; a done pulse left over from an earlier division is
    // ignored in the cycle that starts a new one
    always_comb begin
        n_state = r_state;
        case (r_state)
            ogrc_pkg::ST_IDLE:
                if (w_acc && s_axis_tuser == ogrc_pkg::REQ_RAY) n_state = ogrc_pkg::ST_DIV;
            ogrc_pkg::ST_DIV:
                if ((w_ddone && !r_dfire) || r_n == '0) n_state = ogrc_pkg::ST_STEP;
            ogrc_pkg::ST_STEP: n_state = ogrc_pkg::ST_READ;
            ogrc_pkg::ST_READ: n_state = ogrc_pkg::ST_TEST;
            ogrc_pkg::ST_TEST: begin
                if (r_last || (!r_oob && w_rd > r_thr)) n_state = ogrc_pkg::ST_OUT;
                else n_state = ogrc_pkg::ST_STEP;
            end
            ogrc_pkg::ST_OUT: if (m_axis_tready) n_state = ogrc_pkg::ST_IDLE;
            default: n_state = ogrc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == ogrc_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == ogrc_pkg::ST_OUT);
        w_dstart = r_dfire;
    end
    assign m_axis_tdata = r_out;

    logic [PW-1:0] w_pr;
    logic [PW-SLOPE_FRAC_BITS-1:0] w_off;
    logic [CW-1:0] w_bnext;
    always_comb begin
        w_pr = r_p + (r_minneg ? PW'({SLOPE_FRAC_BITS{1'b1}}) : PW'(0));
        w_off = w_pr[PW-1:SLOPE_FRAC_BITS];
        if (r_minneg) begin
            w_bnext = (w_off <= (PW-SLOPE_FRAC_BITS)'(r_bmin)) ? r_bmin - CW'(w_off) : '0;
        end else begin
            w_bnext = r_bmin + CW'(w_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ogrc_pkg::ST_IDLE;
            r_width <= ogrc_pkg::WIDTH_RST;
            r_thr <= ogrc_pkg::THRESH_RST;
            r_dfire <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dfire <= w_acc && s_axis_tuser == ogrc_pkg::REQ_RAY;
            if (i_cfg_we) begin
                if (i_cfg_index == ogrc_pkg::CFG_MAP_WIDTH) r_width <= i_cfg_data;
                else r_thr <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ogrc_pkg::ST_IDLE: if (w_acc) begin
                r_xmaj <= w_xm;
                r_amaj <= w_xm ? w_sx : w_sy;
                r_aend <= w_xm ? w_ex : w_ey;
                r_bmin <= w_xm ? w_sy : w_sx;
                r_bend <= w_xm ? w_ey : w_ex;
                r_n <= w_xm ? w_dx : w_dy;
                r_minneg <= w_xm ? (w_ey < w_sy) : (w_ex < w_sx);
                r_k <= '0;
            end
            ogrc_pkg::ST_DIV: begin
                r_q <= (r_n == '0) ? '0 : w_quot;
                r_p <= '0;
            end
            ogrc_pkg::ST_STEP: begin
                if (r_k == r_n) begin
                    r_a <= r_aend;
                    r_b <= r_bend;
                    r_last <= 1'b1;
                end else begin
                    r_a <= (r_aend >= r_amaj) ? r_amaj + r_k : r_amaj - r_k;
                    r_b <= w_bnext;
                    r_last <= 1'b0;
                end
                r_p <= r_p + PW'(r_q);
                r_k <= r_k + 1'b1;
            end
            ogrc_pkg::ST_READ: begin
                r_oob <= ({1'b0, w_cx_t} >= w_ew) || ({1'b0, w_cy_t} >= SIDE_C);
            end
            ogrc_pkg::ST_TEST: begin
                r_hit <= !r_oob && w_rd > r_thr;
                r_out <= {5'd0, w_cy_t, w_cx_t, (!r_oob && w_rd > r_thr)};
            end
            default: ;
        endcase
    end

    logic w_unused;
    assign w_unused = r_hit ^ ^s_axis_tdata[63:62];
endmodule

// ----- design/ogrc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ogrc_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_sh;

    always_comb begin
        w_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ----- design/ogrc_map.sv -----
// Map memory: one write port, one registered read port.
module ogrc_map #(
    parameter int ADDR_W = 18
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic signed [ogrc_pkg::VAL_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]               i_raddr,
    output logic signed [ogrc_pkg::VAL_W-1:0] o_rdata
);
    logic signed [ogrc_pkg::VAL_W-1:0] r_mem [2**ADDR_W];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
